FILE: design/pfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_pkg: shared types and constants of the potential field step block
// Field widths, mode and status codes, controller/datapath command and status
// structs, and the output clamp.
// ----------------------------------------------------------------------------
package pfs_pkg;

    localparam int COORD_W = 32;
    localparam int STEP_W  = 31;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STEP   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic accept;
        logic walk;
        logic sq_init;
        logic sq_run;
        logic rt_init;
        logic rt_run;
        logic dv_init;
        logic dv_run;
        logic fin;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic walk_done;
        logic sum_zero;
        logic cnt_done;
    } t_sts;

    // clamp a stepped coordinate into the unsigned 31-bit output range
    function automatic logic [STEP_W-1:0] clamp_out(input logic signed [COORD_W+1:0] v);
        logic [STEP_W-1:0] res;
        priority if (v < 0) begin
            res = '0;
        end else if (v > $signed({3'b000, {STEP_W{1'b1}}})) begin
            res = '1;
        end else begin
            res = v[STEP_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: design/pfs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_in_if: request channel
// Valid/ready channel carrying one mode, position and point kind.
// ----------------------------------------------------------------------------
interface pfs_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          mode;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_z;
    logic                attracts;

    modport source (output valid, output mode, output pos_x, output pos_z,
                    output attracts, input ready);
    modport sink   (input valid, input mode, input pos_x, input pos_z,
                    input attracts, output ready);
endinterface

FILE: design/pfs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_out_if: result channel
// Valid/ready channel carrying the stepped position and a status code.
// ----------------------------------------------------------------------------
interface pfs_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] new_x;
    logic [30:0] new_z;
    logic [1:0]  status;

    modport source (output valid, output new_x, output new_z, output status,
                    input ready);
    modport sink   (input valid, input new_x, input new_z, input status,
                    output ready);
endinterface

FILE: design/potential_field_step.sv
`timescale 1ns / 1ps
// Order: clear, insert and unused modes go from the transfer straight to the push.
// Step: table walk, square, root and scaling in turn, then the push once the output
//   register is free; a zero resultant skips square, root and scaling. Sums are 34 + clog2(MAX_POINTS) bits wide.
// Throughput: one item at a time; the next transfer is taken as soon as the result
//   sits in the output register.
// Reset (synchronous, active low) empties table and output, step_length = 65536.
// ----------------------------------------------------------------------------
// potential_field_step: potential field steering step
// Keeps a table of attracting and repelling points and moves a position one
// step of configured length along the summed field.
// ----------------------------------------------------------------------------
module potential_field_step #(
    parameter int MAX_POINTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfs_in_if.sink      i_req,
    pfs_out_if.source   o_rsp,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata
);
    import pfs_pkg::*;

    logic [STEP_W-1:0] r_step_len;
    logic              r_out_valid;
    logic [STEP_W-1:0] r_out_x, r_out_z;
    logic [STAT_W-1:0] r_out_st;

    t_cmd              cmd;
    t_sts              sts;
    logic              out_free;
    logic [STEP_W-1:0] res_x, res_z;
    logic [STAT_W-1:0] res_st;

    // step length register: to be written only while idle; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_len <= STEP_W'(65536);
        end else if (i_cfg_we) begin
            r_step_len <= i_cfg_wdata;
        end
    end

    // output register: frees the sequencer once a result is parked here
    assign out_free = !r_out_valid || o_rsp.ready;

    pfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid),
        .i_is_step  (i_req.mode == MODE_STEP),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_ready    (i_req.ready),
        .o_cmd      (cmd)
    );

    pfs_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_mode     (i_req.mode),
        .i_pos_x    (i_req.pos_x),
        .i_pos_z    (i_req.pos_z),
        .i_attracts (i_req.attracts),
        .i_step_len (r_step_len),
        .o_res_x    (res_x),
        .o_res_z    (res_z),
        .o_res_st   (res_st)
    );

    // hold the result until the sink takes it; load on push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.push) begin
            r_out_x  <= res_x;
            r_out_z  <= res_z;
            r_out_st <= res_st;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.new_x  = r_out_x;
    assign o_rsp.new_z  = r_out_z;
    assign o_rsp.status = r_out_st;

    // never overwrite a result the sink has not taken
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> (!r_out_valid || o_rsp.ready))
        else $error("result pushed over a pending result");

    // a transfer leaves the idle state at once
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second transfer taken while busy");

    // the unused status code never leaves the block
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.status != 2'd3))
        else $error("invalid status code");
endmodule

FILE: design/pfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/pfs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_datapath: point table, resultant sums, square root and scaling
// Holds the point table and count, walks the table, squares by shift-add,
// takes the floor root two bits a step, and scales one quotient bit a step.
// ----------------------------------------------------------------------------
module pfs_datapath #(
    parameter int MAX_POINTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pfs_pkg::t_cmd      i_cmd,
    output pfs_pkg::t_sts      o_sts,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_z,
    input  logic               i_attracts,
    input  logic [30:0]        i_step_len,
    output logic [30:0]        o_res_x,
    output logic [30:0]        o_res_z,
    output logic [1:0]         o_res_st
);
    import pfs_pkg::*;

    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = COORD_W + 2 + $clog2(MAX_POINTS);
    localparam int MAG_W = SUM_W;
    localparam int SQ_W  = 2 * MAG_W + 2;
    localparam int RT_W  = MAG_W + 1;
    localparam int RM_W  = RT_W + 2;
    localparam int IT_W  = $clog2(RT_W + 1);
    localparam int ENT_W = 2 * COORD_W + 1;

    logic [CW-1:0]              r_count;
    logic [CW-1:0]              r_idx;
    logic                       r_rdv;
    logic signed [COORD_W-1:0]  r_px, r_pz;
    logic signed [SUM_W-1:0]    r_sx, r_sz;
    logic [MAG_W-1:0]           r_magx, r_magz, r_mulx, r_mulz;
    logic [SQ_W-1:0]            r_shx, r_shz, r_acc;
    logic [RM_W-1:0]            r_rem, r_rx, r_rz;
    logic [RT_W-1:0]            r_root;
    logic [STEP_W-1:0]          r_qx, r_qz, r_sl;
    logic [IT_W-1:0]            r_it;
    logic [STEP_W-1:0]          r_res_x, r_res_z;
    logic [STAT_W-1:0]          r_res_st;

    logic                       ram_we, issue, full;
    logic [ENT_W-1:0]           ram_rdata;
    logic signed [COORD_W-1:0]  ent_x, ent_z;
    logic                       ent_att;
    logic signed [COORD_W:0]    ox, oz;
    logic [MAG_W-1:0]           magx, magz;
    logic [RM_W-1:0]            rem2, trial;
    logic [RM_W+1:0]            dvx, dvz;
    logic signed [COORD_W+1:0]  vx, vz;

    // scaling step: r = 2r + bit*a, then take out n twice, once or not at all
    function automatic logic [RM_W+1:0] div_step(input logic [RM_W-1:0] r,
                                                 input logic [MAG_W-1:0] a,
                                                 input logic bit_s,
                                                 input logic [RT_W-1:0] n);
        logic [RM_W-1:0] r2, n1, n2;
        logic [RM_W+1:0] res;
        r2 = {r[RM_W-2:0], 1'b0} + (bit_s ? RM_W'(a) : '0);
        n1 = RM_W'(n);
        n2 = {n1[RM_W-2:0], 1'b0};
        priority if (r2 >= n2) begin
            res = {2'd2, r2 - n2};
        end else if (r2 >= n1) begin
            res = {2'd1, r2 - n1};
        end else begin
            res = {2'd0, r2};
        end
        return res;
    endfunction

    assign full   = (r_count >= CW'(MAX_POINTS));
    assign ram_we = i_cmd.accept && (i_mode == MODE_INSERT) && !full;
    assign issue  = i_cmd.walk && (r_idx != r_count);

    pfs_ram #(.WIDTH(ENT_W), .DEPTH(MAX_POINTS)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_attracts, i_pos_z, i_pos_x}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign ent_x   = ram_rdata[COORD_W-1:0];
    assign ent_z   = ram_rdata[2*COORD_W-1:COORD_W];
    assign ent_att = ram_rdata[ENT_W-1];
    assign ox      = {r_px[COORD_W-1], r_px} - {ent_x[COORD_W-1], ent_x};
    assign oz      = {r_pz[COORD_W-1], r_pz} - {ent_z[COORD_W-1], ent_z};

    assign magx = r_sx[SUM_W-1] ? MAG_W'(-r_sx) : MAG_W'(r_sx);
    assign magz = r_sz[SUM_W-1] ? MAG_W'(-r_sz) : MAG_W'(r_sz);

    assign rem2  = {r_rem[RM_W-3:0], r_acc[SQ_W-1:SQ_W-2]};
    assign trial = {r_root, 2'b01};

    assign dvx = div_step(r_rx, r_magx, r_sl[STEP_W-1], r_root);
    assign dvz = div_step(r_rz, r_magz, r_sl[STEP_W-1], r_root);

    assign vx = r_sx[SUM_W-1] ? (34'(r_px) - $signed({3'b000, r_qx}))
                              : (34'(r_px) + $signed({3'b000, r_qx}));
    assign vz = r_sz[SUM_W-1] ? (34'(r_pz) - $signed({3'b000, r_qz}))
                              : (34'(r_pz) + $signed({3'b000, r_qz}));

    // point count: clear, insert
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.accept && (i_mode == MODE_CLEAR)) begin
            r_count <= '0;
        end else if (ram_we) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdv <= 1'b0;
        end else begin
            r_rdv <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px  <= i_pos_x;
            r_pz  <= i_pos_z;
            r_sx  <= '0;
            r_sz  <= '0;
            r_idx <= '0;
            unique case (i_mode)
                MODE_INSERT: begin
                    r_res_x  <= '0;
                    r_res_z  <= '0;
                    r_res_st <= full ? ST_FULL : ST_OK;
                end
                MODE_STEP: begin
                    // answer for a zero resultant; overwritten on a real step
                    r_res_x  <= clamp_out(34'(i_pos_x));
                    r_res_z  <= clamp_out(34'(i_pos_z));
                    r_res_st <= ST_ZERO;
                end
                default: begin
                    r_res_x  <= '0;
                    r_res_z  <= '0;
                    r_res_st <= ST_OK;
                end
            endcase
        end
        if (issue) begin
            r_idx <= r_idx + CW'(1);
        end
        if (r_rdv) begin
            r_sx <= ent_att ? (r_sx - SUM_W'(ox)) : (r_sx + SUM_W'(ox));
            r_sz <= ent_att ? (r_sz - SUM_W'(oz)) : (r_sz + SUM_W'(oz));
        end
        if (i_cmd.sq_init) begin
            r_magx <= magx;
            r_magz <= magz;
            r_mulx <= magx;
            r_mulz <= magz;
            r_shx  <= SQ_W'(magx);
            r_shz  <= SQ_W'(magz);
            r_acc  <= '0;
            r_it   <= IT_W'(MAG_W);
        end
        if (i_cmd.sq_run) begin
            r_acc  <= r_acc + (r_mulx[0] ? r_shx : '0) + (r_mulz[0] ? r_shz : '0);
            r_shx  <= {r_shx[SQ_W-2:0], 1'b0};
            r_shz  <= {r_shz[SQ_W-2:0], 1'b0};
            r_mulx <= {1'b0, r_mulx[MAG_W-1:1]};
            r_mulz <= {1'b0, r_mulz[MAG_W-1:1]};
            r_it   <= r_it - IT_W'(1);
        end
        if (i_cmd.rt_init) begin
            r_rem  <= '0;
            r_root <= '0;
            r_it   <= IT_W'(RT_W);
        end
        if (i_cmd.rt_run) begin
            r_acc <= {r_acc[SQ_W-3:0], 2'b00};
            if (rem2 >= trial) begin
                r_rem  <= rem2 - trial;
                r_root <= {r_root[RT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem2;
                r_root <= {r_root[RT_W-2:0], 1'b0};
            end
            r_it <= r_it - IT_W'(1);
        end
        if (i_cmd.dv_init) begin
            r_rx <= '0;
            r_rz <= '0;
            r_qx <= '0;
            r_qz <= '0;
            r_sl <= i_step_len;
            r_it <= IT_W'(STEP_W);
        end
        if (i_cmd.dv_run) begin
            r_rx <= dvx[RM_W-1:0];
            r_rz <= dvz[RM_W-1:0];
            r_qx <= {r_qx[STEP_W-2:0], 1'b0} + STEP_W'(dvx[RM_W+1:RM_W]);
            r_qz <= {r_qz[STEP_W-2:0], 1'b0} + STEP_W'(dvz[RM_W+1:RM_W]);
            r_sl <= {r_sl[STEP_W-2:0], 1'b0};
            r_it <= r_it - IT_W'(1);
        end
        if (i_cmd.fin) begin
            r_res_x  <= clamp_out(vx);
            r_res_z  <= clamp_out(vz);
            r_res_st <= ST_OK;
        end
    end

    assign o_sts.walk_done = (r_idx == r_count) && !r_rdv;
    assign o_sts.sum_zero  = (r_sx == '0) && (r_sz == '0);
    assign o_sts.cnt_done  = (r_it == '0);

    assign o_res_x  = r_res_x;
    assign o_res_z  = r_res_z;
    assign o_res_st = r_res_st;
endmodule

FILE: design/pfs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_ctrl: sequencing state machine
// Steps a step request through walk, square, root and scaling (other modes
// and a zero sum skip the rest), and hands the result to the output register.
// ----------------------------------------------------------------------------
module pfs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_is_step,
    input  logic          i_out_free,
    input  pfs_pkg::t_sts i_sts,
    output logic          o_ready,
    output pfs_pkg::t_cmd o_cmd
);
    import pfs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WALK = 6'b000010,
        S_SQ   = 6'b000100,
        S_RT   = 6'b001000,
        S_DV   = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_is_step ? S_WALK : S_DONE;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_done) begin
                    if (i_sts.sum_zero) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.sq_init = 1'b1;
                        n_state       = S_SQ;
                    end
                end
            end
            S_SQ: begin
                if (i_sts.cnt_done) begin
                    o_cmd.rt_init = 1'b1;
                    n_state       = S_RT;
                end else begin
                    o_cmd.sq_run = 1'b1;
                end
            end
            S_RT: begin
                if (i_sts.cnt_done) begin
                    o_cmd.dv_init = 1'b1;
                    n_state       = S_DV;
                end else begin
                    o_cmd.rt_run = 1'b1;
                end
            end
            S_DV: begin
                if (i_sts.cnt_done) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.dv_run = 1'b1;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
